FILE: rtl/core/estv_pkg.sv
// Shared constants, types and the sine table builder for the chirp tone voice.
package estv_pkg;

   // Sine table geometry
   localparam int unsigned SINE_TABLE_BITS = 10;
   localparam int unsigned SINE_SIZE       = 1 << SINE_TABLE_BITS;
   localparam int unsigned QSIZE           = SINE_SIZE >> 2;

   // Fixed-point constants
   localparam int unsigned TONE_SCALE  = 29000;
   localparam logic [14:0] SQUARE_AMP  = 15'd22938;
   localparam logic [31:0] ENV_ONE     = 32'h8000_0000;
   localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
   localparam logic signed [18:0] SAT_HI = 19'sd32000;
   localparam logic signed [18:0] SAT_LO = -19'sd32000;

   // Configuration port
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_INIT_STEP  = 3'd0,
      REG_STEP_RATIO = 3'd1,
      REG_DECAY      = 3'd2,
      REG_GAIN       = 3'd3,
      REG_LENGTH     = 3'd4,
      REG_SQUARE     = 3'd5
   } reg_idx_type;

   localparam logic [30:0] RST_INIT_STEP  = 31'd357913941;
   localparam logic [31:0] RST_STEP_RATIO = 32'd1073741824;
   localparam logic [31:0] RST_DECAY      = 32'hFFFF_FFFF;
   localparam logic [15:0] RST_GAIN       = 16'd32768;
   localparam logic [15:0] RST_LENGTH     = 16'd2205;

   typedef struct packed {
      logic [30:0] initial_phase_step;
      logic [31:0] step_ratio;
      logic [31:0] decay_factor;
      logic [15:0] gain;
      logic [15:0] sweep_length;
      logic        square_mode;
   } cfg_type;

   // Controller to datapath
   typedef struct packed {
      logic load;      // take the input transfer, step voice state
      logic mul_gain;  // step update, tone magnitude times scaled gain
      logic mul_env;   // envelope update, times envelope
      logic emit;      // mix, saturate, fill output register
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_blocked;
   } dp_status_type;

   typedef logic signed [15:0] sine_rom_type [SINE_SIZE];

   // Sine of q/QSIZE quarter turns, 0..32767, from a 9th-order odd polynomial in Q30.
   function automatic logic [15:0] quarter_sine(input logic [31:0] q);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] v;
      x  = (64'(q) * 64'(HALF_PI_Q30)) >> (SINE_TABLE_BITS - 2);
      x2 = (x * x) >> 30;
      t  = ONE_Q30 - x2 / 64'd72;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return v[15:0];
   endfunction

   // Full-cycle table, built from the quarter wave by mirroring.
   function automatic sine_rom_type build_sine();
      sine_rom_type rom;
      logic [31:0]  quad;
      logic [31:0]  r;
      logic [15:0]  v;
      for (int n = 0; n < SINE_SIZE; n++) begin
         quad = 32'(n) >> (SINE_TABLE_BITS - 2);
         r    = 32'(n) & 32'(QSIZE - 1);
         v    = quad[0] ? quarter_sine(32'(QSIZE) - r) : quarter_sine(r);
         rom[n] = quad[1] ? -v : v;
      end
      return rom;
   endfunction

endpackage

FILE: rtl/core/estv_csr.sv
// Configuration register file with APB-style access.
module estv_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [estv_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [estv_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [estv_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready,
   output estv_pkg::cfg_type               cfg
);
   import estv_pkg::*;

   cfg_type     cfg_ff;
   logic        wr_en;
   logic [2:0]  reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.initial_phase_step <= RST_INIT_STEP;
         cfg_ff.step_ratio         <= RST_STEP_RATIO;
         cfg_ff.decay_factor       <= RST_DECAY;
         cfg_ff.gain               <= RST_GAIN;
         cfg_ff.sweep_length       <= RST_LENGTH;
         cfg_ff.square_mode        <= 1'b0;
      end else if (wr_en) begin
         case (reg_idx)
            REG_INIT_STEP:  cfg_ff.initial_phase_step <= csr_pwdata[30:0];
            REG_STEP_RATIO: cfg_ff.step_ratio         <= csr_pwdata;
            REG_DECAY:      cfg_ff.decay_factor       <= csr_pwdata;
            REG_GAIN:       cfg_ff.gain               <= csr_pwdata[15:0];
            REG_LENGTH:     cfg_ff.sweep_length       <= csr_pwdata[15:0];
            REG_SQUARE:     cfg_ff.square_mode        <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_INIT_STEP:  csr_prdata = {1'b0, cfg_ff.initial_phase_step};
         REG_STEP_RATIO: csr_prdata = cfg_ff.step_ratio;
         REG_DECAY:      csr_prdata = cfg_ff.decay_factor;
         REG_GAIN:       csr_prdata = {16'd0, cfg_ff.gain};
         REG_LENGTH:     csr_prdata = {16'd0, cfg_ff.sweep_length};
         REG_SQUARE:     csr_prdata = {31'd0, cfg_ff.square_mode};
         default:        csr_prdata = '0;
      endcase
   end

endmodule

FILE: rtl/core/estv_ctrl.sv
// Sequencer that steps one sample through the datapath.
module estv_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  estv_pkg::dp_status_type status,
   output estv_pkg::dp_cmd_type    cmd
);
   import estv_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GAIN,
      ST_ENV,
      ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_GAIN;
         ST_GAIN: state_in = ST_ENV;
         ST_ENV:  state_in = ST_EMIT;
         ST_EMIT: if (!status.out_blocked) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign cmd.load     = (state_ff == ST_IDLE) && req_valid;
   assign cmd.mul_gain = (state_ff == ST_GAIN);
   assign cmd.mul_env  = (state_ff == ST_ENV);
   assign cmd.emit     = (state_ff == ST_EMIT) && !status.out_blocked;

endmodule

FILE: rtl/core/estv_dp.sv
// Voice state, sine table, shared multipliers, mixer and output register.
module estv_dp (
   input  logic                     clock,
   input  logic                     reset,
   input  estv_pkg::cfg_type        cfg,
   input  estv_pkg::dp_cmd_type     cmd,
   output estv_pkg::dp_status_type  status,
   input  logic signed [15:0]       req_mixin_sample,
   input  logic                     req_start_sweep,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [15:0]       rsp_mixed_sample,
   output logic                     rsp_clipped,
   output logic                     rsp_tone_last,
   output logic                     rsp_tone_active
);
   import estv_pkg::*;

   localparam sine_rom_type SINE_ROM = build_sine();

   // Voice state
   logic [31:0] phase_ff;
   logic [31:0] step_ff;
   logic [31:0] env_ff;
   logic [15:0] count_ff;
   logic        voice_ff;

   // Per-sample working registers
   logic signed [15:0] x_ff;
   logic               active_ff;
   logic               last_ff;
   logic               neg_ff;
   logic signed [15:0] sine_q_ff;
   logic [30:0]        gs_ff;
   logic [63:0]        pa_ff;
   logic [63:0]        pb_ff;

   // Output register
   logic               rsp_valid_ff;
   logic signed [15:0] mixed_ff;
   logic               clipped_ff;
   logic               last_out_ff;
   logic               active_out_ff;

   // Accept-cycle view of the voice after an optional rearm
   logic [31:0] phase_eff;
   logic [31:0] step_eff;
   logic [31:0] env_eff;
   logic [15:0] count_eff;
   logic        voice_eff;
   logic        active_in;
   logic [16:0] count_inc;
   logic        last_in;
   logic [31:0] phase_nxt;

   // Later-step values
   logic [14:0]        mag_s;
   logic               neg_in;
   logic [31:0]        step_sat;
   logic [16:0]        mag;
   logic signed [18:0] tone;
   logic signed [18:0] sum;

   assign phase_eff = req_start_sweep ? 32'd0 : phase_ff;
   assign step_eff  = req_start_sweep ? {1'b0, cfg.initial_phase_step} : step_ff;
   assign env_eff   = req_start_sweep ? ENV_ONE : env_ff;
   assign count_eff = req_start_sweep ? 16'd0 : count_ff;
   assign voice_eff = req_start_sweep | voice_ff;
   assign active_in = voice_eff && (count_eff < cfg.sweep_length);
   assign count_inc = {1'b0, count_eff} + 17'd1;
   assign last_in   = active_in && (count_inc == {1'b0, cfg.sweep_length});
   assign phase_nxt = phase_eff + step_eff;

   always_comb begin
      if (cfg.square_mode) begin
         mag_s  = SQUARE_AMP;
         neg_in = phase_ff[31];
      end else begin
         neg_in = sine_q_ff[15];
         mag_s  = sine_q_ff[15] ? 15'(-sine_q_ff) : sine_q_ff[14:0];
      end
   end

   assign step_sat = (pa_ff[63:62] != 2'b00) ? 32'hFFFF_FFFF : pa_ff[61:30];

   assign mag  = pa_ff[62:46];
   assign tone = neg_ff ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
   assign sum  = 19'(x_ff) + tone;

   // Voice state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         step_ff  <= '0;
         env_ff   <= '0;
         count_ff <= '0;
         voice_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            phase_ff <= active_in ? phase_nxt : phase_eff;
            step_ff  <= step_eff;
            env_ff   <= env_eff;
            count_ff <= active_in ? count_inc[15:0] : count_eff;
            voice_ff <= active_in && !last_in;
         end
         if (cmd.mul_gain && active_ff) begin
            step_ff <= step_sat;
         end
         if (cmd.mul_env && active_ff) begin
            env_ff <= pb_ff[63:32];
         end
      end
   end

   // Working registers and shared multipliers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff      <= req_mixin_sample;
         active_ff <= active_in;
         last_ff   <= last_in;
         sine_q_ff <= SINE_ROM[phase_nxt[31 -: SINE_TABLE_BITS]];
         gs_ff     <= 31'(cfg.gain) * 31'(TONE_SCALE);
         pa_ff     <= 64'(step_eff) * 64'(cfg.step_ratio);
         pb_ff     <= 64'(env_eff) * 64'(cfg.decay_factor);
      end
      if (cmd.mul_gain) begin
         neg_ff <= neg_in;
         pa_ff  <= 64'(mag_s) * 64'(gs_ff);
      end
      if (cmd.mul_env) begin
         pa_ff <= 64'(pa_ff[45:15]) * 64'(env_ff);
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         active_out_ff <= active_ff;
         last_out_ff   <= last_ff;
         if (!active_ff) begin
            mixed_ff   <= x_ff;
            clipped_ff <= 1'b0;
         end else if (sum > SAT_HI) begin
            mixed_ff   <= 16'(SAT_HI);
            clipped_ff <= 1'b1;
         end else if (sum < SAT_LO) begin
            mixed_ff   <= 16'(SAT_LO);
            clipped_ff <= 1'b1;
         end else begin
            mixed_ff   <= 16'(sum);
            clipped_ff <= 1'b0;
         end
      end
   end

   assign status.out_blocked = rsp_valid_ff & rsp_stall;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_mixed_sample   = mixed_ff;
   assign rsp_clipped        = clipped_ff;
   assign rsp_tone_last      = last_out_ff;
   assign rsp_tone_active    = active_out_ff;

endmodule

FILE: rtl/core/exp_sweep_tone_voice_core.sv
// Top level of the exponential chirp voice: registers, sequencer and datapath.
// Each sample steps through accept, gain product, envelope product and mix in turn,
//   set by the dependent chain table read -> gain multiply -> envelope multiply;
//   a new input transfer is taken only after the previous sample leaves the mix step.
// A stalled result holds the sequencer in its mix step until the output register drains.
// Reset (synchronous, active high): voice idle, registers at their defaults, no result pending.
module exp_sweep_tone_voice_core (
   input  logic                            clock,
   input  logic                            reset,
   // input sample channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [15:0]              req_mixin_sample,
   input  logic                            req_start_sweep,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [15:0]              rsp_mixed_sample,
   output logic                            rsp_clipped,
   output logic                            rsp_tone_last,
   output logic                            rsp_tone_active,
   // configuration port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [estv_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [estv_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [estv_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import estv_pkg::*;

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type status;

   // Configuration; the user must write it only while no sample is in flight (not enforced here).
   estv_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Sequencer: accepts a transfer only when idle, then walks the three datapath steps.
   estv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: rearm and phase advance on accept, step and envelope multiplies,
   // sine table lookup, tone scaling, mix and saturation into the output register.
   estv_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cmd              (cmd),
      .status           (status),
      .req_mixin_sample (req_mixin_sample),
      .req_start_sweep  (req_start_sweep),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_mixed_sample (rsp_mixed_sample),
      .rsp_clipped      (rsp_clipped),
      .rsp_tone_last    (rsp_tone_last),
      .rsp_tone_active  (rsp_tone_active)
   );

endmodule

FILE: rtl/core/estv_checker.sv
// Port-level checks for the chirp voice, bound to the top level.
module estv_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [15:0] rsp_mixed_sample,
   input logic               rsp_clipped,
   input logic               rsp_tone_last,
   input logic               rsp_tone_active
);

   // A held result keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_mixed_sample)
         && $stable(rsp_clipped) && $stable(rsp_tone_last) && $stable(rsp_tone_active))
      else $error("stalled result changed");

   // One sample at a time: an accepted transfer closes the input for the next cycle.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second transfer taken while a sample is in flight");

   // Clipping only on tone samples, and only at the saturation limits.
   a_clip_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |-> rsp_tone_active
         && (rsp_mixed_sample == 16'sd32000 || rsp_mixed_sample == -16'sd32000))
      else $error("clip flag without tone at the limit");

   // Pass-through samples carry no tone flags.
   a_idle_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_tone_active |-> !rsp_clipped && !rsp_tone_last)
      else $error("flags set on a pass-through sample");

   // Mixed tone samples stay within the saturation range.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tone_active |->
         rsp_mixed_sample <= 16'sd32000 && rsp_mixed_sample >= -16'sd32000)
      else $error("mixed sample out of range");

endmodule

bind exp_sweep_tone_voice_core estv_checker u_estv_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_mixed_sample (rsp_mixed_sample),
   .rsp_clipped      (rsp_clipped),
   .rsp_tone_last    (rsp_tone_last),
   .rsp_tone_active  (rsp_tone_active)
);

FILE: bench/tb_exp_sweep_tone_voice_core.sv
// Self-checking bench for the chirp tone voice: directed sweeps, then random audio.
module tb_exp_sweep_tone_voice_core;
   import estv_pkg::*;

   localparam int HALF_CYCLE   = 5;
   localparam int RESET_CYCLES = 9;
   localparam int SETTLE       = 8;       // a little over the result latency
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SAT_MAG      = 32000;
   localparam int RAND_PHASES  = 8;
   localparam int PHASE_ITEMS  = 225;

   typedef struct {
      logic signed [15:0] sample;
      logic               start;
   } chirp_in_type;

   typedef struct {
      logic signed [15:0] mixed;
      logic               clipped;
      logic               last;
      logic               active;
   } mix_out_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic signed [15:0]    req_mixin_sample = '0;
   logic                  req_start_sweep = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic signed [15:0]    rsp_mixed_sample;
   logic                  rsp_clipped;
   logic                  rsp_tone_last;
   logic                  rsp_tone_active;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   exp_sweep_tone_voice_core DUT (.*);

   // Voice model state and a shadow of the registers
   logic signed [15:0] sine_lut [SINE_SIZE];
   cfg_type            shadow;
   logic [31:0]        phase_acc_m;
   logic [31:0]        phase_inc_m;
   logic [31:0]        env_m;
   logic [15:0]        tone_count;
   logic               voice_live;

   chirp_in_type sample_backlog [$];
   mix_out_type  mix_forecast [$];
   int        queued_total   = 0;
   int        accepted_total = 0;
   int        fail_count     = 0;
   int        send_gap_pct   = 0;
   int        recv_stall_pct = 0;
   bit        took_transfer  = 1'b0;

   initial begin
      forever #HALF_CYCLE clock = ~clock;
   end

   // Quarter-wave sine, 0..32767, odd polynomial in Q30
   function automatic logic [15:0] quarter_wave(input logic [31:0] q);
      logic [63:0] ang;
      logic [63:0] ang_sq;
      logic [63:0] series;
      logic [63:0] prod;
      logic [63:0] rounded;
      ang     = (64'(q) * 64'(HALF_PI_Q30)) >> (SINE_TABLE_BITS - 2);
      ang_sq  = (ang * ang) >> 30;
      series  = ONE_Q30 - ang_sq / 64'd72;
      series  = ONE_Q30 - ((ang_sq * series) >> 30) / 64'd42;
      series  = ONE_Q30 - ((ang_sq * series) >> 30) / 64'd20;
      series  = ONE_Q30 - ((ang_sq * series) >> 30) / 64'd6;
      prod    = (ang * series) >> 30;
      rounded = (prod * 64'd32767 + (64'd1 << 29)) >> 30;
      if (rounded > 64'd32767) begin
         rounded = 64'd32767;
      end
      return rounded[15:0];
   endfunction

   // Step the voice by one sample and produce the mixed result
   task automatic predict_mix(input logic signed [15:0] smp, input logic st,
                              output mix_out_type r);
      int                 mix_sum;
      int                 contrib;
      logic [31:0]        mag;
      logic               neg;
      logic signed [15:0] lut_val;
      logic [63:0]        scaled;
      logic [63:0]        step_next;
      mix_sum   = smp;
      r.clipped = 1'b0;
      r.last    = 1'b0;
      r.active  = 1'b0;
      // rearm: this sample is already tone sample zero
      if (st) begin
         phase_acc_m = '0;
         phase_inc_m = {1'b0, shadow.initial_phase_step};
         env_m       = ENV_ONE;
         tone_count  = '0;
         voice_live  = 1'b1;
      end
      // length is compared live, so a shortened sweep may end with no tone
      if (voice_live && tone_count >= shadow.sweep_length) begin
         voice_live = 1'b0;
      end
      if (voice_live) begin
         r.active    = 1'b1;
         phase_acc_m = phase_acc_m + phase_inc_m;
         if (shadow.square_mode) begin
            mag = 32'(SQUARE_AMP);
            neg = phase_acc_m[31];
         end else begin
            lut_val = sine_lut[phase_acc_m >> (32 - SINE_TABLE_BITS)];
            neg     = lut_val < 0;
            mag     = neg ? 32'(-int'(lut_val)) : 32'(int'(lut_val));
         end
         scaled  = (64'(mag) * 64'(shadow.gain) * 64'(TONE_SCALE)) >> 15;
         contrib = int'((scaled * 64'(env_m)) >> 46);
         mix_sum = mix_sum + (neg ? -contrib : contrib);
         if (mix_sum > SAT_MAG) begin
            mix_sum   = SAT_MAG;
            r.clipped = 1'b1;
         end
         if (mix_sum < -SAT_MAG) begin
            mix_sum   = -SAT_MAG;
            r.clipped = 1'b1;
         end
         // exponential sweep, pinned at full scale
         step_next   = (64'(phase_inc_m) * 64'(shadow.step_ratio)) >> 30;
         phase_inc_m = (step_next > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : step_next[31:0];
         env_m       = 32'((64'(env_m) * 64'(shadow.decay_factor)) >> 32);
         r.last      = (32'(tone_count) + 32'd1 == 32'(shadow.sweep_length));
         tone_count  = tone_count + 16'd1;
         if (r.last) begin
            voice_live = 1'b0;
         end
      end
      r.mixed = mix_sum[15:0];
   endtask

   // One APB write: setup cycle, then access cycle until pready
   task automatic csr_write(input reg_idx_type idx, input logic [31:0] val);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(int'(idx) * 4);
      csr_pwdata  <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_INIT_STEP:  shadow.initial_phase_step = val[30:0];
         REG_STEP_RATIO: shadow.step_ratio         = val;
         REG_DECAY:      shadow.decay_factor       = val;
         REG_GAIN:       shadow.gain               = val[15:0];
         REG_LENGTH:     shadow.sweep_length       = val[15:0];
         REG_SQUARE:     shadow.square_mode        = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic push_item(input logic signed [15:0] s, input logic st);
      sample_backlog.push_back('{s, st});
      queued_total++;
   endtask

   // Wait until every queued sample is accepted and answered, then settle
   task automatic drain();
      while (accepted_total != queued_total || mix_forecast.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE) @(negedge clock);
   endtask

   // Driver: advance to the next sample after a transfer, or hold the stalled one.
   // Idle and stall decisions are rolled at the falling edge.
   always @(negedge clock) begin : drive_proc
      chirp_in_type nxt;
      if (!req_valid || took_transfer) begin
         if (!reset && sample_backlog.size() != 0 &&
             $urandom_range(0, 99) >= send_gap_pct) begin
            nxt = sample_backlog.pop_front();
            req_mixin_sample <= nxt.sample;
            req_start_sweep  <= nxt.start;
            req_valid        <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   // Monitor: predict on every input transfer, check every output transfer
   always @(posedge clock) begin : watch_proc
      mix_out_type want;
      took_transfer = !reset && req_valid && !req_stall;
      if (took_transfer) begin
         predict_mix(req_mixin_sample, req_start_sweep, want);
         mix_forecast.push_back(want);
         accepted_total++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (mix_forecast.size() == 0) begin
            $error("result with nothing expected: mixed_sample %0d", rsp_mixed_sample);
            fail_count++;
         end else begin
            want = mix_forecast.pop_front();
            if (rsp_mixed_sample !== want.mixed) begin
               $error("mixed_sample: expected %0d, got %0d", want.mixed, rsp_mixed_sample);
               fail_count++;
            end
            if (rsp_clipped !== want.clipped) begin
               $error("clipped: expected %0b, got %0b", want.clipped, rsp_clipped);
               fail_count++;
            end
            if (rsp_tone_last !== want.last) begin
               $error("tone_last: expected %0b, got %0b", want.last, rsp_tone_last);
               fail_count++;
            end
            if (rsp_tone_active !== want.active) begin
               $error("tone_active: expected %0b, got %0b", want.active, rsp_tone_active);
               fail_count++;
            end
         end
      end
   end

   // Watchdog
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      logic [15:0] len_pick;
      logic [31:0] word;
      int          start_pct;
      logic signed [15:0] smp;
      logic [31:0] quadrant;
      logic [31:0] off;
      logic [15:0] qv;

      // Build the model's sine table and reset its state
      for (int n = 0; n < SINE_SIZE; n++) begin
         quadrant    = 32'(n) >> (SINE_TABLE_BITS - 2);
         off         = 32'(n) & 32'(QSIZE - 1);
         qv          = quadrant[0] ? quarter_wave(32'(QSIZE) - off) : quarter_wave(off);
         sine_lut[n] = quadrant[1] ? -qv : qv;
      end
      shadow      = '{RST_INIT_STEP, RST_STEP_RATIO, RST_DECAY, RST_GAIN, RST_LENGTH, 1'b0};
      phase_acc_m = '0;
      phase_inc_m = '0;
      env_m       = '0;
      tone_count  = '0;
      voice_live  = 1'b0;

      // Hold reset, then drop it on a falling edge
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Idle voice: the stream passes through untouched, even at full scale
      push_item(16'sh8000, 1'b0);
      push_item(16'sh7FFF, 1'b0);
      push_item(16'sh0000, 1'b0);
      // Default sine sweep on top of extreme samples
      push_item(16'sh7FFF, 1'b1);
      push_item(16'sh8000, 1'b0);
      push_item(16'sd1234, 1'b0);
      drain();

      // Loud square, short sweep, step driven into saturation
      csr_write(REG_INIT_STEP, 32'h7FFF_FFFF);
      csr_write(REG_STEP_RATIO, 32'hFFFF_FFFF);
      csr_write(REG_DECAY, 32'hFFFF_FFFF);
      csr_write(REG_GAIN, 32'h0000_FFFF);
      csr_write(REG_LENGTH, 32'd3);
      csr_write(REG_SQUARE, 32'd1);
      push_item(16'sh7FFF, 1'b1);
      push_item(16'sh8000, 1'b0);
      push_item(16'sd100, 1'b0);
      push_item(16'sd5, 1'b0);
      drain();

      // Zero length: a rearm gives no tone at all
      csr_write(REG_LENGTH, 32'd0);
      push_item(16'sd7, 1'b1);
      push_item(-16'sd7, 1'b0);
      drain();

      // Sine with a collapsing step and envelope, rearmed while running
      csr_write(REG_LENGTH, 32'd6);
      csr_write(REG_SQUARE, 32'd0);
      csr_write(REG_STEP_RATIO, 32'd0);
      csr_write(REG_DECAY, 32'd0);
      push_item(16'sd0, 1'b1);
      push_item(16'sd0, 1'b0);
      push_item(-16'sd1, 1'b0);
      push_item(16'sd0, 1'b1);
      push_item(16'sd0, 1'b0);
      drain();

      // Zero gain, then shorten the sweep below the count already reached
      csr_write(REG_LENGTH, 32'd20);
      csr_write(REG_DECAY, 32'hFFFF_FFFF);
      csr_write(REG_GAIN, 32'd0);
      csr_write(REG_INIT_STEP, 32'd0);
      csr_write(REG_STEP_RATIO, 32'h4000_0000);
      push_item(16'sd0, 1'b1);
      push_item(16'sd0, 1'b0);
      push_item(16'sd0, 1'b0);
      drain();
      csr_write(REG_LENGTH, 32'd2);
      push_item(16'sd9, 1'b0);
      drain();

      // Random phases: new settings each time, cycling through idle patterns.
      // Voice state carries over, so some phases change settings mid-sweep.
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         case ($urandom_range(0, 2))
            0: word = 32'd0;
            1: word = 32'h7FFF_FFFF;
            default: word = $urandom_range(32'h0010_0000, 32'h2000_0000);
         endcase
         csr_write(REG_INIT_STEP, word);
         case ($urandom_range(0, 4))
            0: word = 32'd0;
            1: word = 32'hFFFF_FFFF;
            2: word = $urandom;
            default: word = 32'h4000_0000 + $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
         endcase
         csr_write(REG_STEP_RATIO, word);
         case ($urandom_range(0, 4))
            0: word = 32'd0;
            1: word = 32'hFFFF_FFFF;
            2: word = $urandom;
            default: word = 32'hF000_0000 | $urandom_range(0, 32'h0FFF_FFFF);
         endcase
         csr_write(REG_DECAY, word);
         case ($urandom_range(0, 3))
            0: word = 32'd0;
            1: word = 32'h0000_FFFF;
            default: word = $urandom_range(0, 65535);
         endcase
         csr_write(REG_GAIN, word);
         case ($urandom_range(0, 9))
            0: len_pick = 16'd0;
            1: len_pick = 16'd1;
            2: len_pick = 16'hFFFF;
            default: len_pick = 16'($urandom_range(2, 40));
         endcase
         csr_write(REG_LENGTH, 32'(len_pick));
         csr_write(REG_SQUARE, 32'($urandom_range(0, 1)));

         case (ph % 4)
            0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_gap_pct = 46; recv_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  recv_stall_pct = 46; end
            default: begin send_gap_pct = 14; recv_stall_pct = 14; end
         endcase

         // mostly complete sweeps with random audio, some rearms mid-sweep
         start_pct = $urandom_range(1, 8);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            case ($urandom_range(0, 7))
               0: smp = 16'sh7FFF;
               1: smp = 16'sh8000;
               2: smp = 16'($urandom_range(0, 4000)) - 16'sd2000;
               default: smp = 16'($urandom);
            endcase
            push_item(smp, ($urandom_range(0, 99) < start_pct) || k == 0);
         end
         drain();
      end

      if (fail_count == 0 && mix_forecast.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
